>>> rtl/idbs_pkg.sv
`default_nettype none
package idbs_pkg;

  typedef enum logic [3:0] {
    PH_INTRO      = 4'd0,
    PH_WAIT_REL   = 4'd1,
    PH_IDLE       = 4'd2,
    PH_HOLD       = 4'd3,
    PH_DEBOUNCE   = 4'd4,
    PH_WAIT_PRESS = 4'd5,
    PH_HOLD2      = 4'd6,
    PH_BEEP       = 4'd7,
    PH_GAP        = 4'd8,
    PH_GROUP_GAP  = 4'd9
  } phase_t;

  typedef enum logic [2:0] {
    REG_BEEP_LEN        = 3'd0,
    REG_BEEP_GAP        = 3'd1,
    REG_GROUP_GAP       = 3'd2,
    REG_DEBOUNCE        = 3'd3,
    REG_TICKS_PER_COUNT = 3'd4
  } cfg_reg_t;

  localparam logic [1:0] GRP_FIVE  = 2'd0;
  localparam logic [1:0] GRP_ONE   = 2'd1;
  localparam logic [1:0] GRP_TENTH = 2'd2;

  localparam logic [15:0] CNT_MAX    = 16'hFFFF;
  localparam logic [1:0]  RES_LAST   = 2'd2;
  localparam logic [3:0]  TENTH_LAST = 4'd9;
  localparam logic [2:0]  KM_LAST    = 3'd4;

  localparam logic [9:0]  BEEP_LEN_RST  = 10'd250;
  localparam logic [9:0]  BEEP_GAP_RST  = 10'd100;
  localparam logic [11:0] GROUP_GAP_RST = 12'd1000;
  localparam logic [9:0]  DEBOUNCE_RST  = 10'd200;
  localparam logic [9:0]  TPC_RST       = 10'd100;

  typedef struct packed {
    logic [9:0]  beep_len;
    logic [9:0]  beep_gap;
    logic [11:0] group_gap;
    logic [9:0]  debounce;
    logic [9:0]  ticks_per_count;
  } cfg_t;

  typedef struct packed {
    logic clear;
    logic inc;
  } dist_cmd_t;

  typedef struct packed {
    logic [15:0] count;
    logic [8:0]  five;
    logic [2:0]  km;
    logic [3:0]  tenth;
  } dist_t;

  typedef struct packed {
    logic       found;
    logic [1:0] idx;
    logic [8:0] size;
  } grp_pick_t;

  // first nonzero group at or after g
  function automatic grp_pick_t grp_pick(logic [1:0] g, logic [8:0] five,
                                         logic [2:0] km, logic [3:0] tenth);
    grp_pick_t p;
    p = '0;
    if (g == GRP_FIVE && five != 9'd0) begin
      p.found = 1'b1;
      p.idx   = GRP_FIVE;
      p.size  = five;
    end else if (g <= GRP_ONE && km != 3'd0) begin
      p.found = 1'b1;
      p.idx   = GRP_ONE;
      p.size  = {6'd0, km};
    end else if (g <= GRP_TENTH && tenth != 4'd0) begin
      p.found = 1'b1;
      p.idx   = GRP_TENTH;
      p.size  = {5'd0, tenth};
    end
    return p;
  endfunction

endpackage
`default_nettype wire

>>> rtl/idbs_in_if.sv
`default_nettype none
interface idbs_in_if;
  logic valid;
  logic ready;
  logic button_pressed;
  modport source (output valid, output button_pressed, input ready);
  modport sink (input valid, input button_pressed, output ready);
endinterface
`default_nettype wire

>>> rtl/idbs_out_if.sv
`default_nettype none
interface idbs_out_if;
  logic        valid;
  logic        ready;
  logic        buzzer_on;
  logic [1:0]  tone_select;
  logic [3:0]  phase;
  logic [15:0] interval_count;
  modport source (output valid, output buzzer_on, output tone_select, output phase,
                  output interval_count, input ready);
  modport sink (input valid, input buzzer_on, input tone_select, input phase,
                input interval_count, output ready);
endinterface
`default_nettype wire

>>> rtl/idbs_cfg_if.sv
`default_nettype none
interface idbs_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [11:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/interval_distance_beep_sequencer_top.sv
// result path: a tick's result reaches out_ch after its transaction is accepted, through
//   the input register and then the result register
// throughput: one tick per cycle while out_ch.ready is high; while a finished result waits on
//   out_ch.ready the empty input register can still take one tick
// reset: synchronous active-low rst_n; starts in the intro tones with all counters
//   cleared and the configuration registers at their default values
`default_nettype none
module interval_distance_beep_sequencer_top (
  input  logic       clk,
  input  logic       rst_n,
  idbs_in_if.sink    in_ch,
  idbs_out_if.source out_ch,
  idbs_cfg_if.sink   cfg_ch
);
  import idbs_pkg::*;

  // input register stage
  logic        in_vld_r;
  logic        in_btn_r;
  // result register stage
  logic        out_vld_r;
  logic        out_buzz_r;
  logic [1:0]  out_tone_r;
  logic [3:0]  out_phase_r;
  logic [15:0] out_count_r;
  // configuration
  cfg_t        cfg_r;

  logic        in_take;
  logic        advance;
  dist_cmd_t   cmd;
  dist_t       digits;
  logic        buzz;
  logic [1:0]  tone;
  logic [3:0]  phase;

  // a tick moves to the result register when that slot is free or being drained;
  // the state update happens in that same cycle
  assign advance     = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !in_vld_r || advance;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_take) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) in_btn_r <= in_ch.button_pressed;
  end

  // sequencer state machine and the running distance counter
  idbs_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (advance),
    .pressed     (in_btn_r),
    .cfg         (cfg_r),
    .digits      (digits),
    .cmd         (cmd),
    .buzzer_on   (buzz),
    .tone_select (tone),
    .phase       (phase)
  );

  idbs_dist u_dist (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .cmd    (cmd),
    .digits (digits)
  );

  // result register: outputs describe the tick as seen from the state before it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_buzz_r  <= buzz;
      out_tone_r  <= tone;
      out_phase_r <= phase;
      out_count_r <= digits.count;
    end
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.buzzer_on      = out_buzz_r;
  assign out_ch.tone_select    = out_tone_r;
  assign out_ch.phase          = out_phase_r;
  assign out_ch.interval_count = out_count_r;

  // configuration writes, always accepted; unknown indexes are dropped
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.beep_len        <= BEEP_LEN_RST;
      cfg_r.beep_gap        <= BEEP_GAP_RST;
      cfg_r.group_gap       <= GROUP_GAP_RST;
      cfg_r.debounce        <= DEBOUNCE_RST;
      cfg_r.ticks_per_count <= TPC_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_BEEP_LEN:        cfg_r.beep_len        <= cfg_ch.data[9:0];
        REG_BEEP_GAP:        cfg_r.beep_gap        <= cfg_ch.data[9:0];
        REG_GROUP_GAP:       cfg_r.group_gap       <= cfg_ch.data;
        REG_DEBOUNCE:        cfg_r.debounce        <= cfg_ch.data[9:0];
        REG_TICKS_PER_COUNT: cfg_r.ticks_per_count <= cfg_ch.data[9:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> rtl/idbs_dist.sv
`default_nettype none
// decisecond counter with distance digits (count/3 in fives, ones, tenths)
// kept alongside it, so no divider is needed
module idbs_dist (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  idbs_pkg::dist_cmd_t   cmd,
  output idbs_pkg::dist_t       digits
);
  import idbs_pkg::*;

  logic [15:0] count_r, count_nxt;
  logic [1:0]  res_r, res_nxt;
  logic [8:0]  five_r, five_nxt;
  logic [2:0]  km_r, km_nxt;
  logic [3:0]  tenth_r, tenth_nxt;

  always_comb begin
    count_nxt = count_r;
    res_nxt   = res_r;
    five_nxt  = five_r;
    km_nxt    = km_r;
    tenth_nxt = tenth_r;
    if (cmd.clear) begin
      count_nxt = '0;
      res_nxt   = '0;
      five_nxt  = '0;
      km_nxt    = '0;
      tenth_nxt = '0;
    end else if (cmd.inc && count_r != CNT_MAX) begin
      count_nxt = count_r + 16'd1;
      if (res_r == RES_LAST) begin
        res_nxt = '0;
        if (tenth_r == TENTH_LAST) begin
          tenth_nxt = '0;
          if (km_r == KM_LAST) begin
            km_nxt   = '0;
            five_nxt = five_r + 9'd1;
          end else begin
            km_nxt = km_r + 3'd1;
          end
        end else begin
          tenth_nxt = tenth_r + 4'd1;
        end
      end else begin
        res_nxt = res_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      res_r   <= '0;
      five_r  <= '0;
      km_r    <= '0;
      tenth_r <= '0;
    end else if (step) begin
      count_r <= count_nxt;
      res_r   <= res_nxt;
      five_r  <= five_nxt;
      km_r    <= km_nxt;
      tenth_r <= tenth_nxt;
    end
  end

  assign digits.count = count_r;
  assign digits.five  = five_r;
  assign digits.km    = km_r;
  assign digits.tenth = tenth_r;

  a_res_range: assert property (@(posedge clk) disable iff (!rst_n) res_r != 2'd3)
    else $error("residue out of range");

  a_digits_match: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(five_r) * 32'd150 + 32'(km_r) * 32'd30 + 32'(tenth_r) * 32'd3 + 32'(res_r))
      == 32'(count_r))
    else $error("distance digits out of step with count");

endmodule
`default_nettype wire

>>> rtl/idbs_ctrl.sv
`default_nettype none
module idbs_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic                  pressed,
  input  idbs_pkg::cfg_t        cfg,
  input  idbs_pkg::dist_t       digits,
  output idbs_pkg::dist_cmd_t   cmd,
  output logic                  buzzer_on,
  output logic [1:0]            tone_select,
  output logic [3:0]            phase
);
  import idbs_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [11:0] timer_r, timer_nxt;
  logic [9:0]  presc_r, presc_nxt;
  logic [8:0]  five_r, five_nxt;
  logic [2:0]  km_r, km_nxt;
  logic [3:0]  tenth_r, tenth_nxt;
  logic [8:0]  beeps_r, beeps_nxt;
  logic [1:0]  gi_r, gi_nxt;

  logic [11:0] timer_inc;
  logic [9:0]  presc_inc;
  logic        tick_hit;
  logic [8:0]  beeps_dec;
  grp_pick_t   pick_first;
  grp_pick_t   pick_next;
  grp_pick_t   pk;
  logic        do_start;

  assign timer_inc  = timer_r + 12'd1;
  assign presc_inc  = presc_r + 10'd1;
  assign tick_hit   = presc_inc >= cfg.ticks_per_count;
  assign beeps_dec  = beeps_r - 9'd1;
  assign pick_first = grp_pick(GRP_FIVE, digits.five, digits.km, digits.tenth);
  assign pick_next  = grp_pick(gi_r + 2'd1, five_r, km_r, tenth_r);

  always_comb begin
    phase_nxt = phase_r;
    timer_nxt = timer_r;
    presc_nxt = presc_r;
    five_nxt  = five_r;
    km_nxt    = km_r;
    tenth_nxt = tenth_r;
    beeps_nxt = beeps_r;
    gi_nxt    = gi_r;
    cmd       = '0;
    do_start  = 1'b0;
    pk        = pick_next;
    unique case (phase_r)
      PH_INTRO: begin
        timer_nxt = timer_inc;
        if (timer_inc >= {2'd0, cfg.beep_len}) begin
          timer_nxt = '0;
          if (gi_r >= GRP_TENTH) begin
            gi_nxt    = GRP_FIVE;
            phase_nxt = PH_WAIT_REL;
          end else begin
            gi_nxt = gi_r + 2'd1;
          end
        end
      end
      PH_WAIT_REL: begin
        if (!pressed) phase_nxt = PH_IDLE;
      end
      PH_IDLE: begin
        if (pressed) begin
          cmd.clear = 1'b1;
          presc_nxt = '0;
          phase_nxt = PH_HOLD;
        end
      end
      PH_HOLD: begin
        presc_nxt = tick_hit ? 10'd0 : presc_inc;
        cmd.inc   = tick_hit;
        if (!pressed) begin
          timer_nxt = '0;
          phase_nxt = PH_DEBOUNCE;
        end
      end
      PH_DEBOUNCE: begin
        presc_nxt = tick_hit ? 10'd0 : presc_inc;
        cmd.inc   = tick_hit;
        timer_nxt = timer_inc;
        if (timer_inc >= {2'd0, cfg.debounce}) begin
          timer_nxt = '0;
          phase_nxt = PH_WAIT_PRESS;
        end
      end
      PH_WAIT_PRESS: begin
        if (pressed) begin
          phase_nxt = PH_HOLD2;
        end else begin
          presc_nxt = tick_hit ? 10'd0 : presc_inc;
          cmd.inc   = tick_hit;
        end
      end
      PH_HOLD2: begin
        if (!pressed) begin
          five_nxt  = digits.five;
          km_nxt    = digits.km;
          tenth_nxt = digits.tenth;
          pk        = pick_first;
          do_start  = 1'b1;
        end
      end
      PH_BEEP: begin
        timer_nxt = timer_inc;
        if (timer_inc >= {2'd0, cfg.beep_len}) begin
          beeps_nxt = beeps_dec;
          timer_nxt = '0;
          if (beeps_dec != 9'd0) begin
            phase_nxt = (cfg.beep_gap != 10'd0) ? PH_GAP : PH_BEEP;
          end else if (gi_r < GRP_TENTH) begin
            if (cfg.group_gap != 12'd0) phase_nxt = PH_GROUP_GAP;
            else do_start = 1'b1;
          end else begin
            gi_nxt    = GRP_FIVE;
            phase_nxt = PH_IDLE;
          end
        end
      end
      PH_GAP: begin
        timer_nxt = timer_inc;
        if (timer_inc >= {2'd0, cfg.beep_gap}) begin
          timer_nxt = '0;
          phase_nxt = PH_BEEP;
        end
      end
      PH_GROUP_GAP: begin
        timer_nxt = timer_inc;
        if (timer_inc >= cfg.group_gap) begin
          timer_nxt = '0;
          do_start  = 1'b1;
        end
      end
      default: begin
        gi_nxt    = GRP_FIVE;
        phase_nxt = PH_IDLE;
      end
    endcase
    // start the chosen group, or go idle when nothing is left to sound
    if (do_start) begin
      if (pk.found) begin
        gi_nxt    = pk.idx;
        beeps_nxt = pk.size;
        timer_nxt = '0;
        phase_nxt = PH_BEEP;
      end else begin
        gi_nxt    = GRP_FIVE;
        phase_nxt = PH_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_INTRO;
      timer_r <= '0;
      presc_r <= '0;
      five_r  <= '0;
      km_r    <= '0;
      tenth_r <= '0;
      beeps_r <= '0;
      gi_r    <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      timer_r <= timer_nxt;
      presc_r <= presc_nxt;
      five_r  <= five_nxt;
      km_r    <= km_nxt;
      tenth_r <= tenth_nxt;
      beeps_r <= beeps_nxt;
      gi_r    <= gi_nxt;
    end
  end

  assign buzzer_on   = (phase_r == PH_INTRO) || (phase_r == PH_BEEP);
  assign tone_select = buzzer_on ? gi_r : 2'd0;
  assign phase       = phase_r;

  a_group_range: assert property (@(posedge clk) disable iff (!rst_n) gi_r != 2'd3)
    else $error("group index out of range");

  a_beep_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_BEEP |-> beeps_r != 9'd0)
    else $error("beep phase with no beeps left");

endmodule
`default_nettype wire
